>>> hw/rtl/energy_meter_request_reply_macros.svh
// Assertion macros used by the bound SVA checker.
`ifndef ENERGY_METER_REQUEST_REPLY_MACROS_SVH
`define ENERGY_METER_REQUEST_REPLY_MACROS_SVH

// same-cycle implication
`define EMRR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("emrr assertion failed");

// next-cycle implication
`define EMRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("emrr assertion failed");

`endif

>>> hw/rtl/emrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package emrr_pkg;

    localparam int FRAME_BYTES = 7;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [2:0] MET_CURRENT = 3'd0;
    localparam logic [2:0] MET_VOLTAGE = 3'd1;
    localparam logic [2:0] MET_POWER   = 3'd2;
    localparam logic [2:0] MET_ENERGY  = 3'd3;
    localparam logic [2:0] MET_SET     = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
    localparam logic [2:0] ST_TIMEOUT     = 3'd2;
    localparam logic [2:0] ST_HEADER      = 3'd3;
    localparam logic [2:0] ST_CHECKSUM    = 3'd4;
    localparam logic [2:0] ST_SET_FAIL    = 3'd5;
    localparam logic [2:0] ST_SET_OK      = 3'd6;

    localparam logic [2:0] REG_VOLTAGE = 3'd0;
    localparam logic [2:0] REG_CURRENT = 3'd1;
    localparam logic [2:0] REG_POWER   = 3'd2;
    localparam logic [2:0] REG_ENERGY  = 3'd3;
    localparam logic [2:0] REG_SET     = 3'd4;

    localparam logic [7:0]  HEADER_OFFSET = 8'h10;
    localparam logic [31:0] DEFAULT_ADDR  = 32'hC0A8_0101;

    localparam logic [1:0] DEC_CURRENT = 2'd2;
    localparam logic [1:0] DEC_VOLTAGE = 2'd1;
    localparam logic [1:0] DEC_NONE    = 2'd0;

    typedef struct packed {
        logic        hit;
        logic [2:0]  status;
        logic [23:0] value;
        logic [1:0]  decimals;
    } t_done;

endpackage

`default_nettype wire

>>> hw/rtl/emrr_rx.sv
`timescale 1ns / 1ps
`default_nettype none

module emrr_rx (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [2:0]         i_metric,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_start_ok,
    input  wire logic [7:0]         i_start_cmd,
    output emrr_pkg::t_done         o_done
);
    import emrr_pkg::*;

    localparam logic [2:0] LAST_IDX = 3'(FRAME_BYTES - 1);

    logic       r_busy;
    logic [2:0] r_metric;
    logic [7:0] r_cmd;
    logic [2:0] r_cnt;
    logic [7:0] r_sum;
    logic [7:0] r_d [0:FRAME_BYTES-2];

    logic [7:0]  n_bad_hdr_cmp;
    logic        hdr_bad;
    logic [7:0]  set_or;
    t_done       done;

    assign n_bad_hdr_cmp = r_cmd - HEADER_OFFSET;
    assign hdr_bad = (r_cmd < HEADER_OFFSET) || (r_d[0] != n_bad_hdr_cmp);
    assign set_or  = r_d[1] | r_d[2] | r_d[3] | r_d[4] | r_d[5];

    always_comb begin
        done = '0;
        case (i_opcode)
            OP_START: begin
                if (!i_start_ok) begin
                    done.hit    = 1'b1;
                    done.status = ST_UNSUPPORTED;
                end
            end
            OP_RX_BYTE: begin
                if (r_busy && r_cnt == LAST_IDX) begin
                    done.hit = 1'b1;
                    if (hdr_bad) begin
                        done.status = ST_HEADER;
                    end else if (i_rx_byte != r_sum) begin
                        done.status = ST_CHECKSUM;
                    end else begin
                        case (r_metric)
                            MET_CURRENT: begin
                                done.value    = 24'(r_d[2]) * 24'd100 + 24'(r_d[3]);
                                done.decimals = DEC_CURRENT;
                            end
                            MET_VOLTAGE: begin
                                done.value    = 24'({r_d[1], r_d[2]}) * 24'd10 + 24'(r_d[3]);
                                done.decimals = DEC_VOLTAGE;
                            end
                            MET_POWER: begin
                                done.value = 24'({r_d[1], r_d[2]});
                            end
                            MET_ENERGY: begin
                                done.value = {r_d[1], r_d[2], r_d[3]};
                            end
                            default: begin
                                done.value  = 24'(set_or);
                                done.status = (set_or != 8'd0) ? ST_SET_FAIL : ST_SET_OK;
                            end
                        endcase
                    end
                end
            end
            OP_TIMEOUT: begin
                if (r_busy) begin
                    done.hit    = 1'b1;
                    done.status = ST_TIMEOUT;
                end
            end
            default: begin
                done = '0;
            end
        endcase
    end

    assign o_done = i_accept ? done : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_metric <= '0;
            r_cmd    <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
        end else if (i_accept) begin
            case (i_opcode)
                OP_START: begin
                    r_busy <= i_start_ok;
                    r_cnt  <= '0;
                    r_sum  <= '0;
                    if (i_start_ok) begin
                        r_metric <= i_metric;
                        r_cmd    <= i_start_cmd;
                    end
                end
                OP_RX_BYTE: begin
                    if (r_busy) begin
                        if (r_cnt != LAST_IDX) begin
                            r_sum <= r_sum + i_rx_byte;
                            r_cnt <= r_cnt + 3'd1;
                        end else begin
                            r_busy <= 1'b0;
                            r_cnt  <= '0;
                            r_sum  <= '0;
                        end
                    end
                end
                OP_TIMEOUT: begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                    r_sum  <= '0;
                end
                default: begin
                    r_busy <= r_busy;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_opcode == OP_RX_BYTE && r_busy && r_cnt != LAST_IDX) begin
            r_d[r_cnt] <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/energy_meter_request_reply.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// s         in         i_s_tvalid/o_s_tready  tdata, tuser
// m         out        o_m_tvalid/i_m_tready  tdata, tuser, tlast
// cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Each input transaction is handled in the cycle it is accepted; results are registered
// and appear on m in the following cycle. A start with a supported metric emits 7 transmit
// beats, one per cycle while m is ready, and holds s until its last beat is taken.
// Every other item that yields a result emits a single result beat. The output register is
// the only stall point: s is ready when it is empty or handing over its final beat. Reset
// (synchronous, active low) idles the block and restores the command registers; cfg is always ready.

module energy_meter_request_reply (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // metric, device_address, address_valid, rx_byte
    input  wire logic [1:0]  i_s_tuser,   // opcode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // tx_byte, status, value, decimals
    output logic             o_m_tuser,   // result_kind
    output logic             o_m_tlast,   // tx_last
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);
    import emrr_pkg::*;

    localparam logic [2:0] LAST_IDX = 3'(FRAME_BYTES - 1);

    logic [7:0] r_cmd_volt, r_cmd_curr, r_cmd_pow, r_cmd_energy, r_cmd_set;

    logic [1:0]  in_op;
    logic [2:0]  in_metric;
    logic [31:0] in_addr;
    logic        in_addr_ok;
    logic [7:0]  in_rx;
    logic        s_acc, out_free, beat_taken;
    logic        start_ok;
    logic [7:0]  start_cmd;
    logic [31:0] addr;
    logic [7:0]  req [0:FRAME_BYTES-1];
    t_done       done;

    logic        r_out_valid, r_kind;
    logic [2:0]  r_idx;
    logic [7:0]  r_frame [0:FRAME_BYTES-1];
    logic [2:0]  r_status;
    logic [23:0] r_value;
    logic [1:0]  r_dec;

    assign in_op      = i_s_tuser;
    assign in_metric  = i_s_tdata[2:0];
    assign in_addr    = i_s_tdata[34:3];
    assign in_addr_ok = i_s_tdata[35];
    assign in_rx      = i_s_tdata[43:36];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_volt   <= 8'd176;
            r_cmd_curr   <= 8'd177;
            r_cmd_pow    <= 8'd178;
            r_cmd_energy <= 8'd179;
            r_cmd_set    <= 8'd180;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VOLTAGE: r_cmd_volt   <= i_cfg_data;
                REG_CURRENT: r_cmd_curr   <= i_cfg_data;
                REG_POWER:   r_cmd_pow    <= i_cfg_data;
                REG_ENERGY:  r_cmd_energy <= i_cfg_data;
                REG_SET:     r_cmd_set    <= i_cfg_data;
                default:     r_cmd_set    <= r_cmd_set;
            endcase
        end
    end

    always_comb begin
        start_ok  = 1'b1;
        start_cmd = 8'd0;
        case (in_metric)
            MET_CURRENT: start_cmd = r_cmd_curr;
            MET_VOLTAGE: start_cmd = r_cmd_volt;
            MET_POWER:   start_cmd = r_cmd_pow;
            MET_ENERGY:  start_cmd = r_cmd_energy;
            MET_SET:     start_cmd = r_cmd_set;
            default:     start_ok  = 1'b0;
        endcase
    end

    assign addr   = in_addr_ok ? in_addr : DEFAULT_ADDR;
    assign req[0] = start_cmd;
    assign req[1] = addr[31:24];
    assign req[2] = addr[23:16];
    assign req[3] = addr[15:8];
    assign req[4] = addr[7:0];
    assign req[5] = 8'd0;
    assign req[6] = req[0] + req[1] + req[2] + req[3] + req[4];

    assign beat_taken = r_out_valid && i_m_tready;
    assign out_free   = !r_out_valid || (i_m_tready && (r_kind || r_idx == LAST_IDX));
    assign o_s_tready = out_free;
    assign s_acc      = i_s_tvalid && out_free;

    emrr_rx u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_acc),
        .i_opcode    (in_op),
        .i_metric    (in_metric),
        .i_rx_byte   (in_rx),
        .i_start_ok  (start_ok),
        .i_start_cmd (start_cmd),
        .o_done      (done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_kind      <= 1'b0;
            r_idx       <= '0;
        end else if (s_acc && in_op == OP_START && start_ok) begin
            r_out_valid <= 1'b1;
            r_kind      <= 1'b0;
            r_idx       <= '0;
        end else if (done.hit) begin
            r_out_valid <= 1'b1;
            r_kind      <= 1'b1;
            r_idx       <= '0;
        end else if (beat_taken) begin
            if (out_free) begin
                r_out_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && in_op == OP_START && start_ok) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_frame[i] <= req[i];
            end
            r_status <= ST_OK;
            r_value  <= '0;
            r_dec    <= DEC_NONE;
        end else if (done.hit) begin
            r_status <= done.status;
            r_value  <= done.value;
            r_dec    <= done.decimals;
        end else if (beat_taken && !r_kind) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                r_frame[i] <= r_frame[i+1];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = !r_kind && r_idx == LAST_IDX;
    assign o_m_tdata  = {3'd0, r_dec, r_value, r_status, (r_kind ? 8'd0 : r_frame[0])};

endmodule

`default_nettype wire

>>> hw/rtl/emrr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "energy_meter_request_reply_macros.svh"

module emrr_sva_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        o_m_tlast
);

    logic held;
    logic tx_beat;
    logic done_beat;
    logic mid_frame_go;

    assign held         = o_m_tvalid && !i_m_tready;
    assign tx_beat      = o_m_tvalid && !o_m_tuser;
    assign done_beat    = o_m_tvalid && o_m_tuser;
    assign mid_frame_go = tx_beat && i_m_tready && !o_m_tlast;

    `EMRR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, held, o_m_tvalid && $stable(o_m_tdata))
    `EMRR_ASSERT_NOW(a_tx_fields, i_clk, i_rst_n, tx_beat, o_m_tdata[39:8] == 32'd0)
    `EMRR_ASSERT_NOW(a_done_tx, i_clk, i_rst_n, done_beat, !o_m_tlast && o_m_tdata[7:0] == 8'd0)
    `EMRR_ASSERT_NEXT(a_frame_runs, i_clk, i_rst_n, mid_frame_go, tx_beat)

endmodule

bind energy_meter_request_reply emrr_sva_checker u_emrr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

>>> sim/emrr_checker.sv
`timescale 1ns / 1ps

module emrr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_beats_pending,
    output int          o_items_seen,
    output int          o_beats_seen
);
    import emrr_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [2:0]  status;
        logic [23:0] value;
        logic [1:0]  decimals;
    } meter_beat_t;

    meter_beat_t beats_due[$];

    logic [7:0] cmd_regs [0:4];
    logic       xfer_busy;
    logic [2:0] xfer_metric;
    logic [7:0] xfer_cmd;
    logic [2:0] rx_count;
    logic [7:0] rx_sum;
    logic [7:0] rx_frame [0:FRAME_BYTES-1];

    int fail_count = 0;
    int item_count = 0;
    int beat_count = 0;

    task automatic close_exchange(input logic [2:0] status, input logic [23:0] value,
                                  input logic [1:0] decimals);
        meter_beat_t beat;
        beat = '{1'b1, 8'd0, 1'b0, status, value, decimals};
        beats_due.push_back(beat);
        xfer_busy = 1'b0;
        rx_count  = '0;
        rx_sum    = '0;
    endtask

    task automatic start_exchange(input logic [2:0] metric, input logic [31:0] addr,
                                  input logic addr_ok);
        logic [7:0]  cmd;
        logic [31:0] dest;
        logic [7:0]  frame [0:FRAME_BYTES-1];
        logic [7:0]  sum;
        meter_beat_t beat;
        xfer_busy = 1'b0;
        rx_count  = '0;
        rx_sum    = '0;
        case (metric)
            MET_CURRENT: cmd = cmd_regs[REG_CURRENT];
            MET_VOLTAGE: cmd = cmd_regs[REG_VOLTAGE];
            MET_POWER:   cmd = cmd_regs[REG_POWER];
            MET_ENERGY:  cmd = cmd_regs[REG_ENERGY];
            MET_SET:     cmd = cmd_regs[REG_SET];
            default: begin
                close_exchange(ST_UNSUPPORTED, 24'd0, DEC_NONE);
                return;
            end
        endcase
        dest = addr_ok ? addr : DEFAULT_ADDR;
        frame[0] = cmd;
        frame[1] = dest[31:24];
        frame[2] = dest[23:16];
        frame[3] = dest[15:8];
        frame[4] = dest[7:0];
        frame[5] = 8'd0;
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum = sum + frame[i];
        frame[FRAME_BYTES-1] = sum;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            beat = '{1'b0, frame[i], (i == FRAME_BYTES - 1), ST_OK, 24'd0, DEC_NONE};
            beats_due.push_back(beat);
        end
        xfer_busy   = 1'b1;
        xfer_metric = metric;
        xfer_cmd    = cmd;
    endtask

    task automatic take_reply_byte(input logic [7:0] b);
        logic [31:0] reading;
        logic [7:0]  merged;
        if (!xfer_busy)
            return;
        rx_frame[rx_count] = b;
        if (rx_count < 3'(FRAME_BYTES - 1)) begin
            rx_sum   = rx_sum + b;
            rx_count = rx_count + 3'd1;
            return;
        end
        // header must be the command less the offset, with no wrap below it
        if (xfer_cmd < HEADER_OFFSET || rx_frame[0] != 8'(xfer_cmd - HEADER_OFFSET)) begin
            close_exchange(ST_HEADER, 24'd0, DEC_NONE);
        end else if (rx_frame[FRAME_BYTES-1] != rx_sum) begin
            close_exchange(ST_CHECKSUM, 24'd0, DEC_NONE);
        end else begin
            case (xfer_metric)
                MET_CURRENT: begin
                    reading = 32'(rx_frame[2]) * 32'd100 + 32'(rx_frame[3]);
                    close_exchange(ST_OK, reading[23:0], DEC_CURRENT);
                end
                MET_VOLTAGE: begin
                    reading = 32'({rx_frame[1], rx_frame[2]}) * 32'd10 + 32'(rx_frame[3]);
                    close_exchange(ST_OK, reading[23:0], DEC_VOLTAGE);
                end
                MET_POWER: begin
                    close_exchange(ST_OK, {8'd0, rx_frame[1], rx_frame[2]}, DEC_NONE);
                end
                MET_ENERGY: begin
                    close_exchange(ST_OK, {rx_frame[1], rx_frame[2], rx_frame[3]}, DEC_NONE);
                end
                default: begin
                    merged = rx_frame[1] | rx_frame[2] | rx_frame[3] | rx_frame[4] | rx_frame[5];
                    close_exchange((merged != 8'd0) ? ST_SET_FAIL : ST_SET_OK,
                                   {16'd0, merged}, DEC_NONE);
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        meter_beat_t want;
        if (!i_rst_n) begin
            beats_due.delete();
            cmd_regs[REG_VOLTAGE] = 8'd176;
            cmd_regs[REG_CURRENT] = 8'd177;
            cmd_regs[REG_POWER]   = 8'd178;
            cmd_regs[REG_ENERGY]  = 8'd179;
            cmd_regs[REG_SET]     = 8'd180;
            xfer_busy   = 1'b0;
            xfer_metric = '0;
            xfer_cmd    = '0;
            rx_count    = '0;
            rx_sum      = '0;
            for (int i = 0; i < FRAME_BYTES; i++)
                rx_frame[i] = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= REG_SET)
                cmd_regs[i_cfg_index] = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                item_count++;
                case (i_s_tuser)
                    OP_START:   start_exchange(i_s_tdata[2:0], i_s_tdata[34:3], i_s_tdata[35]);
                    OP_RX_BYTE: take_reply_byte(i_s_tdata[43:36]);
                    OP_TIMEOUT: begin
                        if (xfer_busy)
                            close_exchange(ST_TIMEOUT, 24'd0, DEC_NONE);
                    end
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                beat_count++;
                if (beats_due.size() == 0) begin
                    $error("result with nothing expected: kind %0b tdata 0x%0h",
                           i_m_tuser, i_m_tdata);
                    fail_count++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(i_m_tuser));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(i_m_tdata[7:0]));
                    check_field("tx_last", 32'(want.tx_last), 32'(i_m_tlast));
                    check_field("status", 32'(want.status), 32'(i_m_tdata[10:8]));
                    check_field("value", 32'(want.value), 32'(i_m_tdata[34:11]));
                    check_field("decimals", 32'(want.decimals), 32'(i_m_tdata[36:35]));
                end
            end
        end
        o_fail_count    <= fail_count;
        o_beats_pending <= beats_due.size();
        o_items_seen    <= item_count;
        o_beats_seen    <= beat_count;
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import emrr_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [2:0] MET_BAD_FIRST = 3'd5;
    localparam logic [2:0] MET_BAD_LAST  = 3'd7;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 4000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [47:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        o_cfg_ready;

    int fail_count;
    int beats_pending;
    int items_seen;
    int beats_seen;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int stim_items    = 0;

    logic [7:0] cmd_now [0:4];

    energy_meter_request_reply uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    emrr_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tuser       (o_m_tuser),
        .i_m_tlast       (o_m_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_beats_pending (beats_pending),
        .o_items_seen    (items_seen),
        .o_beats_seen    (beats_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hold off the output for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack   <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] command_for(input logic [2:0] metric);
        case (metric)
            MET_CURRENT: return cmd_now[REG_CURRENT];
            MET_VOLTAGE: return cmd_now[REG_VOLTAGE];
            MET_POWER:   return cmd_now[REG_POWER];
            MET_ENERGY:  return cmd_now[REG_ENERGY];
            default:     return cmd_now[REG_SET];
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [2:0] metric,
                             input logic [31:0] addr, input logic addr_ok,
                             input logic [7:0] rx, input bit counted);
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'd0, rx, addr_ok, addr, metric};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        if (counted)
            stim_items++;
    endtask

    task automatic send_start(input logic [2:0] metric);
        send_item(OP_START, metric, $urandom, 1'($urandom_range(1)),
                  8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_RX_BYTE, 3'($urandom_range(7)), $urandom, 1'($urandom_range(1)), b, 1'b1);
    endtask

    task automatic send_timeout();
        send_item(OP_TIMEOUT, 3'($urandom_range(7)), $urandom, 1'($urandom_range(1)),
                  8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_reply(input logic [2:0] metric, input logic [39:0] body,
                              input bit bad_header, input bit bad_sum);
        logic [7:0] frame [0:FRAME_BYTES-1];
        logic [7:0] sum;
        frame[0] = command_for(metric) - HEADER_OFFSET;
        if (bad_header)
            frame[0] = frame[0] ^ 8'($urandom_range(255, 1));
        for (int k = 1; k <= 5; k++)
            frame[k] = body[8*(5-k) +: 8];
        sum = '0;
        for (int k = 0; k < FRAME_BYTES - 1; k++)
            sum = sum + frame[k];
        frame[FRAME_BYTES-1] = bad_sum ? (sum ^ 8'($urandom_range(255, 1))) : sum;
        for (int k = 0; k < FRAME_BYTES; k++)
            send_byte(frame[k]);
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (beats_pending != 0) @(posedge i_clk);
    endtask

    task automatic load_commands(input logic [7:0] volt, input logic [7:0] cur,
                                 input logic [7:0] pwr, input logic [7:0] nrg,
                                 input logic [7:0] setc);
        logic [7:0] vals [0:4];
        vals = '{volt, cur, pwr, nrg, setc};
        settle();
        repeat (4) @(posedge i_clk);
        for (int r = REG_VOLTAGE; r <= REG_SET; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            cmd_now[r] = vals[r];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_exchange();
        int          pick;
        int          flaw;
        int          op;
        logic [2:0]  metric;
        logic [39:0] body;
        pick   = $urandom_range(99);
        metric = 3'($urandom_range(4));
        if (pick < 65) begin
            send_start(metric);
            body[39:8] = $urandom;
            body[7:0]  = 8'($urandom_range(255));
            if (metric == MET_SET && $urandom_range(1) == 1)
                body = '0;
            flaw = $urandom_range(99);
            send_reply(metric, body, flaw < 8, flaw >= 8 && flaw < 16);
        end else if (pick < 75) begin
            send_start(metric);
            repeat ($urandom_range(FRAME_BYTES - 1)) send_byte(8'($urandom_range(255)));
            send_timeout();
        end else if (pick < 83) begin
            // abandon mid-frame; the next start drops it
            send_start(metric);
            repeat ($urandom_range(FRAME_BYTES - 1)) send_byte(8'($urandom_range(255)));
        end else if (pick < 89) begin
            send_start(3'($urandom_range(MET_BAD_LAST, MET_BAD_FIRST)));
        end else begin
            op = $urandom_range(3);
            send_item(2'(op), 3'($urandom_range(7)), $urandom, 1'($urandom_range(1)),
                      8'($urandom_range(255)), 1'b1);
        end
    endtask

    initial begin
        cmd_now[REG_VOLTAGE] = 8'd176;
        cmd_now[REG_CURRENT] = 8'd177;
        cmd_now[REG_POWER]   = 8'd178;
        cmd_now[REG_ENERGY]  = 8'd179;
        cmd_now[REG_SET]     = 8'd180;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 19;
        sink_idle_pct <= 55;
        send_item(OP_RX_BYTE, MET_CURRENT, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0);
        send_item(OP_TIMEOUT, MET_SET, 32'h0000_0000, 1'b0, 8'h00, 1'b0);
        send_item(OP_UNUSED, MET_BAD_LAST, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0);
        send_item(OP_START, MET_BAD_FIRST, 32'h0000_0000, 1'b0, 8'h00, 1'b1);
        send_item(OP_START, MET_BAD_LAST, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1);
        send_item(OP_START, MET_CURRENT, 32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1);
        send_item(OP_START, MET_VOLTAGE, 32'h1234_5678, 1'b0, 8'h00, 1'b1);
        send_byte(8'h00);
        send_timeout();
        send_item(OP_START, MET_ENERGY, 32'h0000_0000, 1'b1, 8'h00, 1'b1);
        send_reply(MET_ENERGY, 40'hFF_FFFF_FFFF, 1'b0, 1'b0);
        send_item(OP_START, MET_SET, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b1);
        send_reply(MET_SET, 40'h00_0000_0000, 1'b0, 1'b0);

        load_commands(8'h00, 8'hFF, 8'h10, 8'h0F, 8'h80);
        while (stim_items < 60) random_exchange();

        src_idle_pct  = 55;
        sink_idle_pct <= 19;
        load_commands(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        while (stim_items < 110) random_exchange();

        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        load_commands(8'd176, 8'd177, 8'd178, 8'd179, 8'd180);
        hold_req <= hold_req + 1;
        while (stim_items < 160) random_exchange();

        settle();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d input and %0d output transactions", items_seen, beats_seen);
        $display("over three command settings, mixed idling and one long output hold-off.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
